// File: hw/rtl/linear_regression_gd_trainer_core_assert.svh
// Assertion macros for the trainer RTL.
// Clocked on clk with the active-low synchronous reset rst_n of the including module.
`ifndef LINEAR_REGRESSION_GD_TRAINER_CORE_ASSERT_SVH
`define LINEAR_REGRESSION_GD_TRAINER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LRGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LRGD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRGD_ASSERT(lbl, prop, msg)
`define LRGD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/lrgd_pkg.sv
// Package for the gradient-descent trainer: sizes, op codes, payload and command types.
// No dependencies.
package lrgd_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_FEATURES = 16;
  localparam int VALUE_WIDTH  = 32;
  localparam int ACC_WIDTH    = 48;
  localparam int SUM_WIDTH    = 64;
  localparam int MUL_WIDTH    = VALUE_WIDTH + 1;
  localparam int PROD_WIDTH   = 2 * MUL_WIDTH;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int FC_W   = 5;
  localparam int FEAT_DEPTH = MAX_ROWS * MAX_FEATURES;

  // Input op codes.
  localparam logic [2:0] OP_TRAIN_FEAT   = 3'd0;
  localparam logic [2:0] OP_TRAIN_TARGET = 3'd1;
  localparam logic [2:0] OP_FIT          = 3'd2;
  localparam logic [2:0] OP_TEST_FEAT    = 3'd3;
  localparam logic [2:0] OP_CLEAR        = 3'd4;

  // Result kinds.
  localparam logic KIND_PREDICTION = 1'b0;
  localparam logic KIND_FIT_DONE   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EPOCH_COUNT   = 2'd0;
  localparam logic [1:0] CFG_STEP_RATE     = 2'd1;
  localparam logic [1:0] CFG_USE_INTERCEPT = 2'd2;
  localparam logic [1:0] CFG_FEATURE_COUNT = 2'd3;

  typedef struct packed {
    logic [2:0]                    op;
    logic signed [VALUE_WIDTH-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic                          result_kind;
    logic signed [VALUE_WIDTH-1:0] prediction;
    logic                          saturated;
  } out_item_t;

  typedef struct packed {
    logic [15:0]     epoch_count;
    logic [15:0]     step_rate;
    logic            use_intercept;
    logic [FC_W-1:0] feature_count;
  } cfg_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_WR_FEAT, DP_WR_TGT, DP_CLR_MODEL, DP_ACC_CLR, DP_RD,
    DP_MUL_WX, DP_MUL_WV, DP_MUL_XE, DP_ACC_ADD, DP_FINISH, DP_WR_ERR,
    DP_SUM_CLR, DP_SUM_XE, DP_SUM_E, DP_DIV, DP_STEP_LO, DP_STEP_HI,
    DP_UPD_W, DP_UPD_B, DP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             clr_test;
    logic             test;
    logic             wzero;
    logic             out_kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CNT_W-1:0] count;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

// File: hw/rtl/linear_regression_gd_trainer_core.sv
// Linear regression trainer with full-batch gradient descent in Q16.16 fixed point.
// Load ops and test features are accepted only in the idle state. A test feature busies
// the block through its accumulate step, and a row-closing one also through the finish
// step and the output transfer. A training target also zeroes the columns left open in
// its row (up to 16). A fit runs through the sample stores and one shared multiplier:
// each epoch makes a prediction pass over the n rows, then a gradient pass over the n
// rows for each feature (and one for the intercept when it is on), and a bit-serial
// divider averages each gradient. Sample stores need no clearing pass after reset.
// Depends on lrgd_pkg, lrgd_ctrl and lrgd_dp.
module linear_regression_gd_trainer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrgd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lrgd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  lrgd_pkg::cfg_t     cfg_r;
  lrgd_pkg::dp_cmd_t  cmd;
  lrgd_pkg::dp_stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.epoch_count   <= 16'd100;
      cfg_r.step_rate     <= 16'd655;
      cfg_r.use_intercept <= 1'b1;
      cfg_r.feature_count <= lrgd_pkg::FC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrgd_pkg::CFG_EPOCH_COUNT:   cfg_r.epoch_count   <= cfg_wdata;
        lrgd_pkg::CFG_STEP_RATE:     cfg_r.step_rate     <= cfg_wdata;
        lrgd_pkg::CFG_USE_INTERCEPT: cfg_r.use_intercept <= cfg_wdata[0];
        lrgd_pkg::CFG_FEATURE_COUNT: cfg_r.feature_count <= cfg_wdata[lrgd_pkg::FC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lrgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg       (cfg_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrgd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_value (in_data.sample_value),
    .stat     (stat),
    .out_item (out_data)
  );

endmodule

// File: hw/rtl/lrgd_div.sv
// Sequential signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on lrgd_pkg.
module lrgd_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [lrgd_pkg::SUM_WIDTH-1:0]  dividend,
  input  logic [lrgd_pkg::CNT_W-1:0]             divisor,
  output logic signed [lrgd_pkg::SUM_WIDTH-1:0]  quotient,
  output logic                                   done
);

  localparam int SW    = lrgd_pkg::SUM_WIDTH;
  localparam int DW    = lrgd_pkg::CNT_W;
  localparam int STEPW = $clog2(SW);

  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [STEPW-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [SW-1:0]    q_r;
  logic [DW:0]      trial;
  logic             ge;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem_r, q_r[SW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[SW-1];
        q_r    <= dividend[SW-1] ? (~dividend + 1'b1) : dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
        q_r   <= {q_r[SW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEPW'(SW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restore the sign of the magnitude quotient.
  assign quotient = neg_r ? $signed(~q_r + 1'b1) : $signed(q_r);
  assign done     = done_r;

endmodule

// File: hw/rtl/lrgd_dp.sv
// Datapath of the trainer: sample stores, weights, bias, shared multiplier, accumulators.
// Depends on lrgd_pkg and lrgd_div.
module lrgd_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  lrgd_pkg::dp_cmd_t                        cmd,
  input  lrgd_pkg::cfg_t                           cfg,
  input  logic signed [lrgd_pkg::VALUE_WIDTH-1:0]  in_value,
  output lrgd_pkg::dp_stat_t                       stat,
  output lrgd_pkg::out_item_t                      out_item
);

  localparam int VW = lrgd_pkg::VALUE_WIDTH;
  localparam int AW = lrgd_pkg::ACC_WIDTH;
  localparam int SW = lrgd_pkg::SUM_WIDTH;
  localparam int MW = lrgd_pkg::MUL_WIDTH;
  localparam int PW = lrgd_pkg::PROD_WIDTH;
  localparam int NF = lrgd_pkg::MAX_FEATURES;
  localparam int FAW = lrgd_pkg::ROW_W + lrgd_pkg::COL_W;
  localparam int LOW = VW + 16;
  localparam logic signed [PW-1:0] V_MAX = PW'((64'sd1 <<< (VW - 1)) - 1);
  localparam logic signed [PW-1:0] V_MIN = -V_MAX - 1;
  localparam logic signed [PW-1:0] A_MAX = PW'((64'sd1 <<< (AW - 1)) - 1);
  localparam logic signed [PW-1:0] A_MIN = -A_MAX - 1;
  localparam logic signed [PW-1:0] HALF  = PW'(32768);

  // Sign extension of a value or accumulator to the wide working width.
  function automatic logic signed [PW-1:0] wide_v(input logic signed [VW-1:0] v);
    wide_v = $signed({{(PW-VW){v[VW-1]}}, v});
  endfunction

  function automatic logic signed [PW-1:0] wide_a(input logic signed [AW-1:0] v);
    wide_a = $signed({{(PW-AW){v[AW-1]}}, v});
  endfunction

  function automatic logic signed [VW-1:0] clamp_v(input logic signed [PW-1:0] v);
    if (v > V_MAX) clamp_v = V_MAX[VW-1:0];
    else if (v < V_MIN) clamp_v = V_MIN[VW-1:0];
    else clamp_v = v[VW-1:0];
  endfunction

  function automatic logic over_v(input logic signed [PW-1:0] v);
    over_v = (v > V_MAX) || (v < V_MIN);
  endfunction

  // Rounds a Q.32 product to Q.16: floor((p + 2^15) / 2^16).
  function automatic logic signed [PW-1:0] round16(input logic signed [PW-1:0] p);
    round16 = (p + HALF) >>> 16;
  endfunction

  logic signed [VW-1:0] feat_mem [lrgd_pkg::FEAT_DEPTH];
  logic signed [VW-1:0] tgt_mem  [lrgd_pkg::MAX_ROWS];
  logic signed [VW-1:0] err_mem  [lrgd_pkg::MAX_ROWS];

  logic signed [VW-1:0] w_r [NF];
  logic signed [VW-1:0] bias_r;
  logic signed [AW-1:0] acc_r;
  logic signed [SW-1:0] sum_r;
  logic signed [PW-1:0] prod_r;
  logic [LOW-1:0]       lo_r;
  logic signed [VW-1:0] feat_q_r;
  logic signed [VW-1:0] tgt_q_r;
  logic signed [VW-1:0] err_q_r;
  logic                 fit_sat_r;
  logic                 test_sat_r;
  lrgd_pkg::out_item_t  out_r;

  logic [FAW-1:0]       feat_addr;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] div_q;
  logic                 div_done;
  logic signed [PW-1:0] acc_sum;
  logic signed [PW-1:0] xe_rnd;
  logic signed [PW-1:0] fin_sum;
  logic signed [PW-1:0] err_diff;
  logic signed [PW-1:0] step_full;
  logic signed [PW-1:0] step_rnd;
  logic signed [PW-1:0] w_new;
  logic signed [PW-1:0] b_new;
  logic signed [VW-1:0] fin_v;
  logic signed [VW-1:0] wdata;

  assign feat_addr = {cmd.row, cmd.col};
  assign wdata     = cmd.wzero ? '0 : in_value;

  // Feature store: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.op == lrgd_pkg::DP_WR_FEAT) begin
      feat_mem[feat_addr] <= wdata;
    end
    if (cmd.op == lrgd_pkg::DP_RD) begin
      feat_q_r <= feat_mem[feat_addr];
    end
  end

  // Target store.
  always_ff @(posedge clk) begin
    if (cmd.op == lrgd_pkg::DP_WR_TGT) begin
      tgt_mem[cmd.row] <= in_value;
    end
    if (cmd.op == lrgd_pkg::DP_RD) begin
      tgt_q_r <= tgt_mem[cmd.row];
    end
  end

  // Error store, written at the end of each row's prediction.
  always_ff @(posedge clk) begin
    if (cmd.op == lrgd_pkg::DP_WR_ERR) begin
      err_mem[cmd.row] <= clamp_v(err_diff);
    end
    if (cmd.op == lrgd_pkg::DP_RD) begin
      err_q_r <= err_mem[cmd.row];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      lrgd_pkg::DP_MUL_WX: begin
        mul_a = MW'(w_r[cmd.col]);
        mul_b = MW'(feat_q_r);
      end
      lrgd_pkg::DP_MUL_WV: begin
        mul_a = MW'(w_r[cmd.col]);
        mul_b = MW'(in_value);
      end
      lrgd_pkg::DP_MUL_XE: begin
        mul_a = MW'(feat_q_r);
        mul_b = MW'(err_q_r);
      end
      lrgd_pkg::DP_STEP_LO: begin
        mul_a = $signed({1'b0, div_q[31:0]});
        mul_b = $signed({{(MW-16){1'b0}}, cfg.step_rate});
      end
      lrgd_pkg::DP_STEP_HI: begin
        mul_a = $signed({{(MW-16){div_q[AW-1]}}, div_q[AW-1:32]});
        mul_b = $signed({{(MW-16){1'b0}}, cfg.step_rate});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Adders behind the product register.
  assign xe_rnd    = round16(prod_r);
  assign acc_sum   = wide_a(acc_r) + xe_rnd;
  assign fin_sum   = wide_a(acc_r) + wide_v(bias_r);
  assign fin_v     = clamp_v(fin_sum);
  assign err_diff  = wide_v(acc_r[VW-1:0]) - wide_v(tgt_q_r);
  assign step_full = (prod_r <<< 32) + $signed({{(PW-LOW){1'b0}}, lo_r});
  assign step_rnd  = round16(step_full);
  assign w_new     = wide_v(w_r[cmd.col]) - step_rnd;
  assign b_new     = wide_v(bias_r) - step_rnd;

  // Arithmetic registers, sequenced by the controller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NF; k++) w_r[k] <= '0;
      bias_r     <= '0;
      acc_r      <= '0;
      fit_sat_r  <= 1'b0;
      test_sat_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        lrgd_pkg::DP_CLR_MODEL: begin
          for (int k = 0; k < NF; k++) w_r[k] <= '0;
          bias_r    <= '0;
          fit_sat_r <= 1'b0;
        end
        lrgd_pkg::DP_ACC_CLR: acc_r <= '0;
        lrgd_pkg::DP_MUL_WX, lrgd_pkg::DP_MUL_WV, lrgd_pkg::DP_MUL_XE,
        lrgd_pkg::DP_STEP_LO: prod_r <= prod;
        lrgd_pkg::DP_STEP_HI: begin
          lo_r   <= prod_r[LOW-1:0];
          prod_r <= prod;
        end
        lrgd_pkg::DP_ACC_ADD: begin
          if (acc_sum > A_MAX) acc_r <= A_MAX[AW-1:0];
          else if (acc_sum < A_MIN) acc_r <= A_MIN[AW-1:0];
          else acc_r <= acc_sum[AW-1:0];
          if ((acc_sum > A_MAX) || (acc_sum < A_MIN)) begin
            if (cmd.test) test_sat_r <= 1'b1;
            else fit_sat_r <= 1'b1;
          end
        end
        lrgd_pkg::DP_FINISH: begin
          acc_r <= AW'(fin_v);
          if (over_v(fin_sum)) begin
            if (cmd.test) test_sat_r <= 1'b1;
            else fit_sat_r <= 1'b1;
          end
        end
        lrgd_pkg::DP_WR_ERR: begin
          if (over_v(err_diff)) fit_sat_r <= 1'b1;
        end
        lrgd_pkg::DP_SUM_CLR: sum_r <= '0;
        lrgd_pkg::DP_SUM_XE:  sum_r <= sum_r + xe_rnd[SW-1:0];
        lrgd_pkg::DP_SUM_E:   sum_r <= sum_r + SW'(err_q_r);
        lrgd_pkg::DP_UPD_W: begin
          w_r[cmd.col] <= clamp_v(w_new);
          if (over_v(w_new)) fit_sat_r <= 1'b1;
        end
        lrgd_pkg::DP_UPD_B: begin
          bias_r <= clamp_v(b_new);
          if (over_v(b_new)) fit_sat_r <= 1'b1;
        end
        default: begin
        end
      endcase
      // A test-row clear comes last so that a result loaded this cycle sees the old values.
      if (cmd.clr_test) begin
        acc_r      <= '0;
        test_sat_r <= 1'b0;
      end
    end
  end

  // Output register, loaded when a result is ready for transfer.
  always_ff @(posedge clk) begin
    if (cmd.op == lrgd_pkg::DP_LOAD_OUT) begin
      out_r.result_kind <= cmd.out_kind;
      if (cmd.out_kind == lrgd_pkg::KIND_FIT_DONE) begin
        out_r.prediction <= '0;
        out_r.saturated  <= fit_sat_r;
      end else begin
        out_r.prediction <= acc_r[VW-1:0];
        out_r.saturated  <= test_sat_r;
      end
    end
  end

  lrgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == lrgd_pkg::DP_DIV),
    .dividend (sum_r),
    .divisor  (cmd.count),
    .quotient (div_q),
    .done     (div_done)
  );

  assign stat.div_done = div_done;
  assign out_item      = out_r;

endmodule

// File: hw/rtl/lrgd_ctrl.sv
// Controller of the trainer: handshakes, row and column counters, fit sequencing.
// Depends on lrgd_pkg and linear_regression_gd_trainer_core_assert.svh.
`include "linear_regression_gd_trainer_core_assert.svh"
module lrgd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lrgd_pkg::cfg_t     cfg,
  input  lrgd_pkg::dp_stat_t stat,
  output lrgd_pkg::dp_cmd_t  cmd
);

  localparam int CW = lrgd_pkg::CNT_W;
  localparam int FW = lrgd_pkg::FC_W;
  localparam int RW = lrgd_pkg::ROW_W;
  localparam int KW = lrgd_pkg::COL_W;
  localparam logic [CW-1:0] ROWS_MAX = CW'(lrgd_pkg::MAX_ROWS);
  localparam logic [FW-1:0] FEAT_MAX = FW'(lrgd_pkg::MAX_FEATURES);

  typedef enum logic [4:0] {
    S_IDLE, S_FILL, S_T_ACC, S_T_FIN, S_T_OUT,
    S_F_INIT, S_P_CLR, S_P_RD, S_P_MUL, S_P_ADD, S_P_FIN, S_P_ERR,
    S_G_CLR, S_G_RD, S_G_MUL, S_G_ADD, S_G_DIV, S_G_WAIT,
    S_G_SLO, S_G_SHI, S_G_UPD, S_F_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] rows_r, rows_nxt;
  logic [FW-1:0] col_r, col_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [FW-1:0] j_r, j_nxt;
  logic [15:0]   ep_r, ep_nxt;
  logic          b_r, b_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [FW-1:0] fc;
  logic [FW-1:0] tc;
  logic          free;
  logic          load;
  logic          more_rows;
  logic          more_cols;
  logic          more_epochs;

  // Effective row width and the column used by a test feature.
  always_comb begin
    if (cfg.feature_count == '0) fc = FW'(1);
    else if (cfg.feature_count > FEAT_MAX) fc = FEAT_MAX;
    else fc = cfg.feature_count;
    tc = (col_r < fc) ? col_r : fc - 1'b1;
  end

  assign free        = !out_valid_r || out_ready;
  assign more_rows   = (i_r + 1'b1) < rows_r;
  assign more_cols   = (j_r + 1'b1) < fc;
  assign more_epochs = ({1'b0, ep_r} + 17'd1) < {1'b0, cfg.epoch_count};
  assign in_ready    = (state_r == S_IDLE);

  // Next state, counters and datapath command.
  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    col_nxt   = col_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ep_nxt    = ep_r;
    b_nxt     = b_r;
    last_nxt  = last_r;
    load      = 1'b0;
    cmd          = '0;
    cmd.op       = lrgd_pkg::DP_NOP;
    cmd.row      = i_r[RW-1:0];
    cmd.col      = j_r[KW-1:0];
    cmd.count    = rows_r;
    cmd.out_kind = lrgd_pkg::KIND_PREDICTION;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            lrgd_pkg::OP_TRAIN_FEAT: begin
              cmd.clr_test = 1'b1;
              if ((rows_r < ROWS_MAX) && (col_r < fc)) begin
                cmd.op  = lrgd_pkg::DP_WR_FEAT;
                cmd.row = rows_r[RW-1:0];
                cmd.col = col_r[KW-1:0];
                col_nxt = col_r + 1'b1;
              end
            end
            lrgd_pkg::OP_TRAIN_TARGET: begin
              cmd.clr_test = 1'b1;
              col_nxt      = '0;
              if (rows_r < ROWS_MAX) begin
                cmd.op  = lrgd_pkg::DP_WR_TGT;
                cmd.row = rows_r[RW-1:0];
                if (col_r < FEAT_MAX) begin
                  j_nxt     = col_r;
                  state_nxt = S_FILL;
                end else begin
                  rows_nxt = rows_r + 1'b1;
                end
              end
            end
            lrgd_pkg::OP_FIT: state_nxt = S_F_INIT;
            lrgd_pkg::OP_TEST_FEAT: begin
              cmd.op    = lrgd_pkg::DP_MUL_WV;
              cmd.col   = tc[KW-1:0];
              last_nxt  = (tc + 1'b1) >= fc;
              col_nxt   = ((tc + 1'b1) >= fc) ? '0 : tc + 1'b1;
              state_nxt = S_T_ACC;
            end
            lrgd_pkg::OP_CLEAR: begin
              cmd.clr_test = 1'b1;
              rows_nxt     = '0;
              col_nxt      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // Zero the columns that a short training row left open.
      S_FILL: begin
        cmd.op    = lrgd_pkg::DP_WR_FEAT;
        cmd.wzero = 1'b1;
        cmd.row   = rows_r[RW-1:0];
        if (j_r == FEAT_MAX - 1'b1) begin
          rows_nxt  = rows_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_T_ACC: begin
        cmd.op    = lrgd_pkg::DP_ACC_ADD;
        cmd.test  = 1'b1;
        state_nxt = last_r ? S_T_FIN : S_IDLE;
      end
      S_T_FIN: begin
        cmd.op    = lrgd_pkg::DP_FINISH;
        cmd.test  = 1'b1;
        state_nxt = S_T_OUT;
      end
      S_T_OUT: begin
        if (free) begin
          cmd.op       = lrgd_pkg::DP_LOAD_OUT;
          cmd.clr_test = 1'b1;
          load         = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_F_INIT: begin
        cmd.op       = lrgd_pkg::DP_CLR_MODEL;
        cmd.clr_test = 1'b1;
        col_nxt      = '0;
        ep_nxt       = '0;
        i_nxt        = '0;
        if ((rows_r == '0) || (cfg.epoch_count == '0)) state_nxt = S_F_OUT;
        else state_nxt = S_P_CLR;
      end
      // Prediction pass over all rows.
      S_P_CLR: begin
        cmd.op    = lrgd_pkg::DP_ACC_CLR;
        j_nxt     = '0;
        state_nxt = S_P_RD;
      end
      S_P_RD: begin
        cmd.op    = lrgd_pkg::DP_RD;
        state_nxt = S_P_MUL;
      end
      S_P_MUL: begin
        cmd.op    = lrgd_pkg::DP_MUL_WX;
        state_nxt = S_P_ADD;
      end
      S_P_ADD: begin
        cmd.op = lrgd_pkg::DP_ACC_ADD;
        if (more_cols) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_P_RD;
        end else begin
          state_nxt = S_P_FIN;
        end
      end
      S_P_FIN: begin
        cmd.op    = lrgd_pkg::DP_FINISH;
        state_nxt = S_P_ERR;
      end
      S_P_ERR: begin
        cmd.op = lrgd_pkg::DP_WR_ERR;
        if (more_rows) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_P_CLR;
        end else begin
          j_nxt     = '0;
          b_nxt     = 1'b0;
          state_nxt = S_G_CLR;
        end
      end
      // Gradient pass, one weight at a time, then the bias when the intercept is on.
      S_G_CLR: begin
        cmd.op    = lrgd_pkg::DP_SUM_CLR;
        i_nxt     = '0;
        state_nxt = S_G_RD;
      end
      S_G_RD: begin
        cmd.op    = lrgd_pkg::DP_RD;
        state_nxt = b_r ? S_G_ADD : S_G_MUL;
      end
      S_G_MUL: begin
        cmd.op    = lrgd_pkg::DP_MUL_XE;
        state_nxt = S_G_ADD;
      end
      S_G_ADD: begin
        cmd.op = b_r ? lrgd_pkg::DP_SUM_E : lrgd_pkg::DP_SUM_XE;
        if (more_rows) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_G_RD;
        end else begin
          state_nxt = S_G_DIV;
        end
      end
      S_G_DIV: begin
        cmd.op    = lrgd_pkg::DP_DIV;
        state_nxt = S_G_WAIT;
      end
      S_G_WAIT: begin
        if (stat.div_done) state_nxt = S_G_SLO;
      end
      S_G_SLO: begin
        cmd.op    = lrgd_pkg::DP_STEP_LO;
        state_nxt = S_G_SHI;
      end
      S_G_SHI: begin
        cmd.op    = lrgd_pkg::DP_STEP_HI;
        state_nxt = S_G_UPD;
      end
      S_G_UPD: begin
        cmd.op = b_r ? lrgd_pkg::DP_UPD_B : lrgd_pkg::DP_UPD_W;
        if (!b_r && more_cols) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_G_CLR;
        end else if (!b_r && cfg.use_intercept) begin
          b_nxt     = 1'b1;
          state_nxt = S_G_CLR;
        end else if (more_epochs) begin
          ep_nxt    = ep_r + 1'b1;
          i_nxt     = '0;
          state_nxt = S_P_CLR;
        end else begin
          state_nxt = S_F_OUT;
        end
      end
      S_F_OUT: begin
        if (free) begin
          cmd.op       = lrgd_pkg::DP_LOAD_OUT;
          cmd.out_kind = lrgd_pkg::KIND_FIT_DONE;
          cmd.clr_test = 1'b1;
          load         = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // State, counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      col_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      ep_r        <= '0;
      b_r         <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      col_r       <= col_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      ep_r        <= ep_nxt;
      b_r         <= b_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // The stored row count never passes the store depth.
  `LRGD_ASSERT(a_rows_bound, rows_r <= ROWS_MAX, "row count beyond store depth")
  // The column counter never passes the row width limit.
  `LRGD_ASSERT(a_col_bound, col_r <= FEAT_MAX, "column counter beyond row width")
  // A finished fit with a free output slot raises valid next cycle.
  `LRGD_ASSERT(a_fit_out, (state_r == S_F_OUT) && free |=> out_valid_r, "fit result lost")
  // Reset leaves no result pending.
  `LRGD_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
